FILE: rtl/urbm_pkg.sv
// ----------------------------------------------------------------------------
// urbm_pkg
// shared types and constants for the uart ring buffer manager
// ----------------------------------------------------------------------------
package urbm_pkg;

    localparam int RING_DEPTH = 128;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_RX_BYTE    = 2'd0,
        OP_HOST_READ  = 2'd1,
        OP_HOST_WRITE = 2'd2,
        OP_TX_DONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_RX_EMPTY    = 2'd1,
        ST_RX_OVERFLOW = 2'd2,
        ST_TX_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [FILL_W-1:0] fill;
    } t_ring_stat;

    typedef struct packed {
        logic       line_valid;
        logic       line_from_ring;
        logic [7:0] data_byte;
        logic       read_valid;
        logic       tx_busy;
        t_status    status;
        logic [7:0] rx_count;
        logic [7:0] tx_count;
    } t_stage;

endpackage

FILE: rtl/urbm_if.sv
// ----------------------------------------------------------------------------
// urbm_in_if / urbm_out_if
// valid/ready channels for events in and results out
// ----------------------------------------------------------------------------
interface urbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface urbm_out_if;
    logic       valid;
    logic       ready;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       tx_irq_enabled;
    logic [1:0] status;
    logic [7:0] rx_count;
    logic [7:0] tx_count;

    modport source (
        output valid, output line_valid, output line_byte, output read_valid,
        output read_byte, output tx_irq_enabled, output status,
        output rx_count, output tx_count, input ready
    );
    modport sink (
        input valid, input line_valid, input line_byte, input read_valid,
        input read_byte, input tx_irq_enabled, input status,
        input rx_count, input tx_count, output ready
    );
endinterface

FILE: rtl/urbm_ring.sv
// ----------------------------------------------------------------------------
// urbm_ring
// byte ring with write/read pointers, fill level and registered read port
// ----------------------------------------------------------------------------
module urbm_ring
    import urbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_pop,
    input  logic       i_rd_en,
    input  logic [7:0] i_data,
    output t_ring_stat o_stat,
    output logic [7:0] o_rd_data
);

    logic [7:0]        r_mem [RING_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [FILL_W-1:0] n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end else if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_stat.full  = (r_fill == FILL_W'(RING_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_stat.fill  = r_fill;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full ring");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty ring");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill did not advance on push");
`endif

endmodule

FILE: rtl/uart_ring_buffer_manager_core.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_manager_core
// receive and transmit byte rings between a uart line and a host
// an accepted event is registered in the first stage, then in the output register
// throughput: one event per cycle while the result side gives no back-pressure
// ring read data comes from a registered memory port in the first stage
// reset: synchronous active low, both rings empty and transmitter idle
// ----------------------------------------------------------------------------
module uart_ring_buffer_manager_core
    import urbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    urbm_in_if.sink    i_in,
    urbm_out_if.source o_out
);

    t_op        op;
    logic       in_fire;
    logic       s1_go;
    t_ring_stat rx_stat;
    t_ring_stat tx_stat;
    logic [7:0] rx_q;
    logic [7:0] tx_q;
    logic       rx_push;
    logic       rx_pop;
    logic       tx_push;
    logic       tx_pop;

    logic       r_busy;
    logic       n_busy;
    logic       r_s1_valid;
    t_stage     r_s1;
    t_stage     n_s1;
    logic       r_out_valid;

    assign op      = t_op'(i_in.operation);
    assign s1_go   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire = i_in.valid && i_in.ready;

    assign rx_push = in_fire && (op == OP_RX_BYTE) && !rx_stat.full;
    assign rx_pop  = in_fire && (op == OP_HOST_READ) && !rx_stat.empty;
    assign tx_push = in_fire && (op == OP_HOST_WRITE) && r_busy && !tx_stat.full;
    assign tx_pop  = in_fire && (op == OP_TX_DONE) && !tx_stat.empty;

    urbm_ring u_rx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (rx_push),
        .i_pop     (rx_pop),
        .i_rd_en   (in_fire),
        .i_data    (i_in.data_byte),
        .o_stat    (rx_stat),
        .o_rd_data (rx_q)
    );

    urbm_ring u_tx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (tx_push),
        .i_pop     (tx_pop),
        .i_rd_en   (in_fire),
        .i_data    (i_in.data_byte),
        .o_stat    (tx_stat),
        .o_rd_data (tx_q)
    );

    always_comb begin
        n_busy              = r_busy;
        n_s1.line_valid     = 1'b0;
        n_s1.line_from_ring = 1'b0;
        n_s1.data_byte      = i_in.data_byte;
        n_s1.read_valid     = 1'b0;
        n_s1.status         = ST_OK;
        case (op)
            OP_RX_BYTE: begin
                if (rx_stat.full) begin
                    n_s1.status = ST_RX_OVERFLOW;
                end
            end
            OP_HOST_READ: begin
                if (rx_stat.empty) begin
                    n_s1.status = ST_RX_EMPTY;
                end else begin
                    n_s1.read_valid = 1'b1;
                end
            end
            OP_HOST_WRITE: begin
                if (!r_busy) begin
                    n_busy          = 1'b1;
                    n_s1.line_valid = 1'b1;
                end else if (tx_stat.full) begin
                    n_s1.status = ST_TX_OVERFLOW;
                end
            end
            default: begin
                if (tx_stat.empty) begin
                    n_busy = 1'b0;
                end else begin
                    n_s1.line_valid     = 1'b1;
                    n_s1.line_from_ring = 1'b1;
                end
            end
        endcase
        n_s1.tx_busy  = n_busy;
        n_s1.rx_count = 8'(rx_stat.fill + FILL_W'(rx_push) - FILL_W'(rx_pop));
        n_s1.tx_count = 8'(tx_stat.fill + FILL_W'(tx_push) - FILL_W'(tx_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_busy <= n_busy;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
        if (s1_go) begin
            o_out.line_valid     <= r_s1.line_valid;
            o_out.line_byte      <= !r_s1.line_valid ? 8'd0 :
                                    (r_s1.line_from_ring ? tx_q : r_s1.data_byte);
            o_out.read_valid     <= r_s1.read_valid;
            o_out.read_byte      <= r_s1.read_valid ? rx_q : 8'd0;
            o_out.tx_irq_enabled <= r_s1.tx_busy;
            o_out.status         <= r_s1.status;
            o_out.rx_count       <= r_s1.rx_count;
            o_out.tx_count       <= r_s1.tx_count;
        end
    end

    assign o_out.valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_tx_queue_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> tx_stat.empty)
        else $error("transmit ring holds bytes while idle");
    a_one_ring_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({rx_push, rx_pop, tx_push, tx_pop}) <= 1)
        else $error("more than one ring operation per event");
    a_out_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.line_valid && o_out.read_valid))
        else $error("line and read results in one word");
    a_irq_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && op == OP_HOST_WRITE) |=> r_busy)
        else $error("host write left transmitter idle");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the uart ring buffer manager against a cycle-free model of both
// rings; events are driven from a queue with random gaps, results are taken
// with random back-pressure and compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urbm_pkg::*;

    typedef struct {
        t_op        op;
        logic [7:0] data;
    } uart_event_t;

    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       tx_irq;
        t_status    status;
        logic [7:0] rx_count;
        logic [7:0] tx_count;
    } uart_result_t;

    typedef enum int {
        MIX_ANY,
        MIX_RX_FILL,
        MIX_RX_DRAIN,
        MIX_TX_FILL,
        MIX_TX_DRAIN
    } mix_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    urbm_in_if  in_bus ();
    urbm_out_if out_bus ();

    uart_ring_buffer_manager_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #5 clk = ~clk;

    // model state of both rings
    logic [7:0]        rx_mem [RING_DEPTH];
    logic [7:0]        tx_mem [RING_DEPTH];
    logic [PTR_W-1:0]  rx_wr = '0, rx_rd = '0, tx_wr = '0, tx_rd = '0;
    logic [FILL_W-1:0] rx_fill = '0, tx_fill = '0;
    logic              tx_busy = 1'b0;

    uart_event_t  pending_events [$];
    uart_result_t expected_results [$];

    int  error_count   = 0;
    int  events_done   = 0;
    int  results_seen  = 0;
    int  events_queued = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  in_taken      = 1'b0;

    function automatic logic [PTR_W-1:0] ring_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic uart_result_t ring_predict(t_op op, logic [7:0] data);
        uart_result_t r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_RX_BYTE: begin
                if (rx_fill < RING_DEPTH) begin
                    rx_mem[rx_wr] = data;
                    rx_wr = ring_inc(rx_wr);
                    rx_fill = rx_fill + 1'b1;
                end else begin
                    r.status = ST_RX_OVERFLOW;
                end
            end
            OP_HOST_READ: begin
                if (rx_fill == 0) begin
                    r.status = ST_RX_EMPTY;
                end else begin
                    r.read_valid = 1'b1;
                    r.read_byte = rx_mem[rx_rd];
                    rx_rd = ring_inc(rx_rd);
                    rx_fill = rx_fill - 1'b1;
                end
            end
            OP_HOST_WRITE: begin
                if (!tx_busy) begin
                    tx_busy = 1'b1;
                    r.line_valid = 1'b1;
                    r.line_byte = data;
                end else if (tx_fill < RING_DEPTH) begin
                    tx_mem[tx_wr] = data;
                    tx_wr = ring_inc(tx_wr);
                    tx_fill = tx_fill + 1'b1;
                end else begin
                    r.status = ST_TX_OVERFLOW;
                end
            end
            default: begin
                if (tx_fill == 0) begin
                    tx_busy = 1'b0;
                end else begin
                    r.line_valid = 1'b1;
                    r.line_byte = tx_mem[tx_rd];
                    tx_rd = ring_inc(tx_rd);
                    tx_fill = tx_fill - 1'b1;
                end
            end
        endcase
        r.tx_irq = tx_busy;
        r.rx_count = 8'(rx_fill);
        r.tx_count = 8'(tx_fill);
        return r;
    endfunction

    task automatic log_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // no gaps on either side over a middle stretch of the run
    function automatic bit stall_roll();
        if (events_done >= 600 && events_done < 900) begin
            return 1'b0;
        end
        return $urandom_range(99) < 17;
    endfunction

    initial begin
        in_bus.valid = 1'b0;
        in_bus.operation = OP_RX_BYTE;
        in_bus.data_byte = 8'h00;
        out_bus.ready = 1'b0;
    end

    // event driver
    always @(posedge clk) begin
        in_taken = rst_n && in_bus.valid && in_bus.ready;
        if (in_taken) begin
            expected_results.push_back(ring_predict(pending_events[0].op,
                                                    pending_events[0].data));
            pending_events.pop_front();
            events_done++;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!(in_bus.valid && !in_taken)) begin
            if (pending_events.size() != 0 && !stall_roll()) begin
                in_bus.valid <= 1'b1;
                in_bus.operation <= pending_events[0].op;
                in_bus.data_byte <= pending_events[0].data;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        uart_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                log_error($sformatf("result %0d arrived with no event waiting",
                                    results_seen));
            end else begin
                want = expected_results.pop_front();
                status_seen[want.status]++;
                if (out_bus.line_valid !== want.line_valid)
                    log_error($sformatf("result %0d line_valid got %0b want %0b",
                              results_seen, out_bus.line_valid, want.line_valid));
                if (out_bus.line_byte !== want.line_byte)
                    log_error($sformatf("result %0d line_byte got %0h want %0h",
                              results_seen, out_bus.line_byte, want.line_byte));
                if (out_bus.read_valid !== want.read_valid)
                    log_error($sformatf("result %0d read_valid got %0b want %0b",
                              results_seen, out_bus.read_valid, want.read_valid));
                if (out_bus.read_byte !== want.read_byte)
                    log_error($sformatf("result %0d read_byte got %0h want %0h",
                              results_seen, out_bus.read_byte, want.read_byte));
                if (out_bus.tx_irq_enabled !== want.tx_irq)
                    log_error($sformatf("result %0d tx_irq_enabled got %0b want %0b",
                              results_seen, out_bus.tx_irq_enabled, want.tx_irq));
                if (out_bus.status !== want.status)
                    log_error($sformatf("result %0d status got %0d want %0d",
                              results_seen, out_bus.status, want.status));
                if (out_bus.rx_count !== want.rx_count)
                    log_error($sformatf("result %0d rx_count got %0d want %0d",
                              results_seen, out_bus.rx_count, want.rx_count));
                if (out_bus.tx_count !== want.tx_count)
                    log_error($sformatf("result %0d tx_count got %0d want %0d",
                              results_seen, out_bus.tx_count, want.tx_count));
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= !stall_roll();
        end
    end

    task automatic queue_event(t_op op, logic [7:0] data);
        uart_event_t ev;
        ev.op = op;
        ev.data = data;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic queue_mix(mix_mode_t mode, int len);
        t_op op;
        bit  main_pick;
        for (int i = 0; i < len; i++) begin
            main_pick = $urandom_range(99) < 85;
            case (mode)
                MIX_RX_FILL:  op = main_pick ? OP_RX_BYTE : OP_HOST_READ;
                MIX_RX_DRAIN: op = main_pick ? OP_HOST_READ : OP_RX_BYTE;
                MIX_TX_FILL:  op = main_pick ? OP_HOST_WRITE : OP_TX_DONE;
                MIX_TX_DRAIN: op = main_pick ? OP_TX_DONE : OP_HOST_WRITE;
                default:      op = t_op'($urandom_range(3));
            endcase
            queue_event(op, 8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (pending_events.size() != 0 || expected_results.size() != 0);
        repeat (4) @(negedge clk);
        #1;
    endtask

    initial begin
        bit paused;
        paused = 1'b0;

        // empty rings, idle transmitter, extreme data values
        queue_event(OP_HOST_READ, 8'h00);
        queue_event(OP_TX_DONE, 8'h00);
        queue_event(OP_RX_BYTE, 8'h00);
        queue_event(OP_RX_BYTE, 8'hFF);
        queue_event(OP_RX_BYTE, 8'hA5);
        queue_event(OP_HOST_READ, 8'hFF);
        queue_event(OP_HOST_READ, 8'h00);
        queue_event(OP_HOST_READ, 8'h5A);
        queue_event(OP_HOST_READ, 8'hFF);
        queue_event(OP_HOST_WRITE, 8'hFF);
        queue_event(OP_HOST_WRITE, 8'h00);
        queue_event(OP_HOST_WRITE, 8'h5A);
        queue_event(OP_TX_DONE, 8'hFF);
        queue_event(OP_TX_DONE, 8'h00);
        queue_event(OP_TX_DONE, 8'h00);
        queue_event(OP_TX_DONE, 8'hFF);
        queue_event(OP_HOST_WRITE, 8'h81);
        queue_event(OP_RX_BYTE, 8'h7E);
        queue_event(OP_TX_DONE, 8'h00);
        queue_event(OP_HOST_READ, 8'h00);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_drained();

        // fill-heavy runs on the receive and transmit rings, then random mixes
        queue_mix(MIX_RX_FILL, 150);
        queue_mix(MIX_TX_FILL, 150);
        while (events_queued < 1750) begin
            if (!paused && events_queued >= 900) begin
                wait_drained();
                paused = 1'b1;
            end
            queue_mix(mix_mode_t'($urandom_range(4)), $urandom_range(20, 160));
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0) begin
            log_error($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("covered %0d events and %0d results, ring depth %0d",
                 events_done, results_seen, RING_DEPTH);
        $display("empty reads %0d, rx overflows %0d, tx overflows %0d, errors %0d",
                 status_seen[ST_RX_EMPTY], status_seen[ST_RX_OVERFLOW],
                 status_seen[ST_TX_OVERFLOW], error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d events pending and %0d results outstanding",
                 pending_events.size(), expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/urbm_pkg.sv
rtl/urbm_if.sv
rtl/urbm_ring.sv
rtl/uart_ring_buffer_manager_core.sv
verif/tb_top.sv
